[hdl/sfsp_pkg.sv]
package sfsp_pkg;

  localparam int CNT_W = 23;
  localparam logic [CNT_W-1:0] MAX_FILE_BYTES = 23'd4194304;
  localparam logic [CNT_W-1:0] CNT_SAT = MAX_FILE_BYTES + 23'd1;
  localparam logic [CNT_W-1:0] HDR_BYTES = 23'd24;
  localparam logic [31:0] MAX_TABS = 32'd256;
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [15:0] URL_LEN_RST = 16'd16384;
  localparam logic [15:0] TITLE_LEN_RST = 16'd4096;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_VERSION  = 3'd2;
  localparam logic [2:0] ST_COUNT    = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_RECORD   = 3'd5;
  localparam logic [2:0] ST_TRAILING = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  localparam logic [1:0] KIND_URL   = 2'd0;
  localparam logic [1:0] KIND_TITLE = 2'd1;
  localparam logic [1:0] KIND_TAB   = 2'd2;
  localparam logic [1:0] KIND_VERD  = 2'd3;

  localparam logic CFG_URL   = 1'b0;
  localparam logic CFG_TITLE = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER     = 4'd0,
    PH_URL_LEN    = 4'd1,
    PH_URL_DATA   = 4'd2,
    PH_TITLE_LEN  = 4'd3,
    PH_TITLE_DATA = 4'd4,
    PH_FLAGS      = 4'd5,
    PH_TAIL       = 4'd6,
    PH_TAIL_BAD   = 4'd7,
    PH_SINK       = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] tab_index;
    logic       pinned;
    logic       muted;
    logic [2:0] status;
    logic [7:0] hdr_active;
    logic [8:0] tab_count;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] m;
    unique case (i)
      3'd0: m = 8'h41;
      3'd1: m = 8'h55;
      3'd2: m = 8'h52;
      3'd3: m = 8'h53;
      3'd4: m = 8'h45;
      3'd5: m = 8'h53;
      3'd6: m = 8'h53;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'h0);
    end
    return x;
  endfunction

endpackage

[hdl/sfsp_out_fifo.sv]
module sfsp_out_fifo
  import sfsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  out_t        mem [4];
  logic [1:0]  head_r, head_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem[head_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= 3'd2);

  always_comb begin
    head_nxt = pop ? head_r + 2'd1 : head_r;
    tail_nxt = tail_r + push.n;
    cnt_nxt  = cnt_r + {1'b0, push.n} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[tail_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[tail_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("fifo count overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> cnt_r <= 3'd2)
    else $error("push without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 3'd4 |-> (tail_r - head_r) == cnt_r[1:0])
    else $error("fifo pointers disagree with count");
`endif

endmodule

[hdl/session_file_stream_parser_top.sv]
// Session file stream parser: one file byte per request, one request per clock while the
// result queue has room. Each byte updates the header check, the CRC-32 (over bytes 8 to 19
// and from byte 24 on) and the record parser and drops up to two results (a URL/title byte
// or completed tab, plus the verdict on the last byte) into a four-entry result queue; input
// stalls only when that queue holds more than two results. Results reach the output in the
// cycle after the byte is taken at the earliest, later while older results still wait in the
// queue. After a verdict all file state clears and the next byte starts a new file.
module session_file_stream_parser_top
  import sfsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]      max_url_r, max_title_r;
  phase_t           ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [1:0]       wbp_r, wbp_nxt;
  logic [8:0]       hc_r, hc_nxt;
  logic             hc_over_r, hc_over_nxt;
  logic [7:0]       ha_r, ha_nxt;
  logic [31:0]      chk_r, chk_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [8:0]       tc_r, tc_nxt;
  logic [2:0]       fe_r, fe_nxt;
  logic             rec_r, rec_nxt;

  logic             accept, room;
  logic [7:0]       b;
  logic [1:0]       sh;
  logic [31:0]      w;
  logic             rec_done;
  logic             item_v;
  out_t             item, verd;
  logic [2:0]       vstat;
  push_t            push;

  assign in_stall = !room;
  assign accept   = in_valid && room;
  assign b        = in_data.byte_value;
  assign sh       = (ph_r == PH_HEADER) ? cnt_r[1:0] : wbp_r;
  assign w        = acc_r | ({24'h0, b} << {sh, 3'b000});
  assign rec_done = (wbp_r == 2'd3);

  always_comb begin
    ph_nxt      = ph_r;
    cnt_nxt     = (cnt_r < CNT_SAT) ? cnt_r + 23'd1 : cnt_r;
    crc_nxt     = crc_r;
    acc_nxt     = acc_r;
    wbp_nxt     = wbp_r;
    hc_nxt      = hc_r;
    hc_over_nxt = hc_over_r;
    ha_nxt      = ha_r;
    chk_nxt     = chk_r;
    rem_nxt     = rem_r;
    tc_nxt      = tc_r;
    fe_nxt      = fe_r;
    rec_nxt     = rec_r;
    item_v      = 1'b0;
    item        = '0;
    item.tab_index = tc_r[7:0];

    if ((cnt_r >= 23'd8 && cnt_r < 23'd20) || cnt_r >= HDR_BYTES) begin
      crc_nxt = crc_byte(crc_r, b);
    end

    unique case (ph_r)
      PH_HEADER: begin
        if (cnt_r < 23'd8) begin
          if (b != magic_byte(cnt_r[2:0]) && fe_r == ST_OK) fe_nxt = ST_HEADER;
        end else if (cnt_r[1:0] == 2'd3) begin
          acc_nxt = '0;
          priority if (cnt_r == 23'd11) begin
            if (w != 32'd1 && fe_r == ST_OK) fe_nxt = ST_VERSION;
          end else if (cnt_r == 23'd15) begin
            hc_nxt      = w[8:0];
            hc_over_nxt = (w > MAX_TABS);
          end else if (cnt_r == 23'd19) begin
            ha_nxt = w[7:0];
            if (fe_r == ST_OK && (hc_over_r ||
                (hc_r == 9'd0 ? w != 32'd0 : w >= {23'h0, hc_r}))) fe_nxt = ST_COUNT;
          end else begin
            chk_nxt = w;
            wbp_nxt = '0;
            if (fe_r != ST_OK) ph_nxt = PH_SINK;
            else ph_nxt = (hc_r == 9'd0) ? PH_TAIL : PH_URL_LEN;
          end
        end else begin
          acc_nxt = w;
        end
      end
      PH_URL_LEN, PH_TITLE_LEN, PH_FLAGS: begin
        if (rec_done) begin
          acc_nxt = '0;
          wbp_nxt = '0;
          if (ph_r == PH_URL_LEN) begin
            if (w > {16'h0, max_url_r}) begin
              rec_nxt = 1'b1;
              ph_nxt  = PH_SINK;
            end else if (w == 32'd0) begin
              if (fe_r == ST_OK) fe_nxt = ST_EMPTY;
              ph_nxt = PH_TITLE_LEN;
            end else begin
              rem_nxt = w[15:0];
              ph_nxt  = PH_URL_DATA;
            end
          end else if (ph_r == PH_TITLE_LEN) begin
            if (w > {16'h0, max_title_r}) begin
              rec_nxt = 1'b1;
              ph_nxt  = PH_SINK;
            end else if (w == 32'd0) begin
              ph_nxt = PH_FLAGS;
            end else begin
              rem_nxt = w[15:0];
              ph_nxt  = PH_TITLE_DATA;
            end
          end else begin
            if (w > 32'd3) begin
              rec_nxt = 1'b1;
              ph_nxt  = PH_SINK;
            end else begin
              item_v      = 1'b1;
              item.kind   = KIND_TAB;
              item.pinned = w[0];
              item.muted  = w[1];
              tc_nxt      = tc_r + 9'd1;
              ph_nxt      = (tc_nxt >= hc_r) ? PH_TAIL : PH_URL_LEN;
            end
          end
        end else begin
          acc_nxt = w;
          wbp_nxt = wbp_r + 2'd1;
        end
      end
      PH_URL_DATA, PH_TITLE_DATA: begin
        item_v         = 1'b1;
        item.kind      = (ph_r == PH_URL_DATA) ? KIND_URL : KIND_TITLE;
        item.data_byte = b;
        rem_nxt        = rem_r - 16'd1;
        if (rem_nxt == 16'd0) ph_nxt = (ph_r == PH_URL_DATA) ? PH_TITLE_LEN : PH_FLAGS;
      end
      PH_TAIL: ph_nxt = PH_TAIL_BAD;
      PH_TAIL_BAD, PH_SINK: ;
      default: ;
    endcase

    priority if (cnt_nxt < HDR_BYTES || cnt_nxt > MAX_FILE_BYTES || fe_nxt == ST_HEADER)
      vstat = ST_HEADER;
    else if (fe_nxt == ST_VERSION || fe_nxt == ST_COUNT) vstat = fe_nxt;
    else if (~crc_nxt != chk_nxt) vstat = ST_CHECKSUM;
    else if (rec_nxt || (ph_nxt >= PH_URL_LEN && ph_nxt <= PH_FLAGS)) vstat = ST_RECORD;
    else if (ph_nxt == PH_TAIL_BAD) vstat = ST_TRAILING;
    else if (fe_nxt == ST_EMPTY) vstat = ST_EMPTY;
    else vstat = ST_OK;

    verd              = '0;
    verd.kind         = KIND_VERD;
    verd.tab_index    = tc_nxt[7:0];
    verd.status       = vstat;
    verd.hdr_active   = ha_nxt;
    verd.tab_count    = hc_nxt;
    verd.run_last     = 1'b1;

    push = '0;
    if (accept) begin
      if (item_v) begin
        push.r0 = item;
        if (in_data.is_last) begin
          push.n  = 2'd2;
          push.r1 = verd;
        end else begin
          push.n           = 2'd1;
          push.r0.run_last = 1'b1;
        end
      end else if (in_data.is_last) begin
        push.n  = 2'd1;
        push.r0 = verd;
      end
    end

    if (in_data.is_last) begin
      ph_nxt      = PH_HEADER;
      cnt_nxt     = '0;
      crc_nxt     = 32'hffffffff;
      acc_nxt     = '0;
      wbp_nxt     = '0;
      hc_nxt      = '0;
      hc_over_nxt = 1'b0;
      ha_nxt      = '0;
      chk_nxt     = '0;
      rem_nxt     = '0;
      tc_nxt      = '0;
      fe_nxt      = ST_OK;
      rec_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_url_r   <= URL_LEN_RST;
      max_title_r <= TITLE_LEN_RST;
      ph_r        <= PH_HEADER;
      cnt_r       <= '0;
      crc_r       <= 32'hffffffff;
      acc_r       <= '0;
      wbp_r       <= '0;
      hc_r        <= '0;
      hc_over_r   <= 1'b0;
      ha_r        <= '0;
      chk_r       <= '0;
      rem_r       <= '0;
      tc_r        <= '0;
      fe_r        <= ST_OK;
      rec_r       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_URL) max_url_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_TITLE) max_title_r <= cfg_data;
      if (accept) begin
        ph_r      <= ph_nxt;
        cnt_r     <= cnt_nxt;
        crc_r     <= crc_nxt;
        acc_r     <= acc_nxt;
        wbp_r     <= wbp_nxt;
        hc_r      <= hc_nxt;
        hc_over_r <= hc_over_nxt;
        ha_r      <= ha_nxt;
        chk_r     <= chk_nxt;
        rem_r     <= rem_nxt;
        tc_r      <= tc_nxt;
        fe_r      <= fe_nxt;
        rec_r     <= rec_nxt;
      end
    end
  end

  sfsp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_tabs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r >= PH_URL_LEN && ph_r <= PH_FLAGS) |-> (tc_r < hc_r && !hc_over_r))
    else $error("record parse past tab count");
  a_rec_sink: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r |-> ph_r == PH_SINK)
    else $error("record error without sink");
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_URL_DATA || ph_r == PH_TITLE_DATA) |-> rem_r != 16'd0)
    else $error("data phase with zero length");
`endif

endmodule
